[hdl/irpp_pkg.sv]
`default_nettype none

package irpp_pkg;

  // Default depth of the pattern memory in bytes.
  localparam int unsigned PATTERN_DEPTH_DEFAULT = 256;

  // The pulse-length table always has sixteen entries.
  localparam int unsigned PULSE_ENTRIES = 16;
  localparam int unsigned PULSE_AW      = $clog2(PULSE_ENTRIES);

  // Field widths.
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned ADDR_W  = 8;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DUR_W   = 16;
  localparam int unsigned CFG_IW  = 3;
  localparam int unsigned CFG_DW  = 8;

  // Input commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK          = 3'd0,
    CMD_START         = 3'd1,
    CMD_STOP          = 3'd2,
    CMD_WRITE_PULSE   = 3'd3,
    CMD_WRITE_PATTERN = 3'd4
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IW-1:0] {
    CFG_OFFSET_FIRST  = 3'd0,
    CFG_OFFSET_REPEAT = 3'd1,
    CFG_OFFSET_FINAL  = 3'd2,
    CFG_LENGTH_FIRST  = 3'd3,
    CFG_LENGTH_REPEAT = 3'd4,
    CFG_LENGTH_FINAL  = 3'd5
  } cfg_idx_t;

  // Playback phase.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MARK  = 2'd1,
    PH_SPACE = 2'd2
  } phase_t;

  // Pattern parts.
  localparam logic [1:0] PART_FIRST  = 2'd0;
  localparam logic [1:0] PART_REPEAT = 2'd1;
  localparam logic [1:0] PART_FINAL  = 2'd2;

  // Per-item information that travels down the pipeline with the item.
  typedef struct packed {
    logic has_dur;  // a mark or space is emitted, duration comes from the table
    logic carrier;  // the emitted interval is a mark
    logic busy;     // playback is active after this item
  } step_t;

endpackage

`default_nettype wire

[hdl/ir_pulse_pattern_player.sv]
`default_nettype none

// Infrared raw-pattern player. Each accepted transaction (tick, start, stop,
// pulse-table write or pattern write) returns exactly one result after the
// pattern memory read followed by the pulse-table read, each a synchronous
// memory with registered data. One transaction is accepted every clock
// cycle unless in_stall holds it while a result waits under out_stall. A
// tick emits the next mark (carrier_on high) or space with its duration from
// the pulse table; other commands return carrier_on low and duration zero.
// busy_res reports whether a pattern is playing after the transaction.
// Configuration registers are written through the cfg port, which is always
// ready, and should only be written while no transaction is in flight.
// Tables are not cleared at reset and must be written before being played.
module ir_pulse_pattern_player #(
  parameter int unsigned PATTERN_DEPTH = irpp_pkg::PATTERN_DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [irpp_pkg::CMD_W-1:0]    command,
  input  wire logic [irpp_pkg::ADDR_W-1:0]   address,
  input  wire logic [irpp_pkg::VALUE_W-1:0]  value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               carrier_on,
  output logic [irpp_pkg::DUR_W-1:0]         duration,
  output logic                               busy_res,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [irpp_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [irpp_pkg::CFG_DW-1:0]   cfg_data
);

  localparam int unsigned AW = $clog2(PATTERN_DEPTH);

  logic            accept;
  irpp_pkg::step_t step;
  logic [AW-1:0]   rd_addr;

  assign cfg_ready = 1'b1;

  // Playback sequencer.
  irpp_ctrl #(
    .PATTERN_DEPTH(PATTERN_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .step_en   (accept),
    .command   (command),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .rd_addr   (rd_addr)
  );

  // Memory lookup pipeline and output register.
  irpp_datapath #(
    .PATTERN_DEPTH(PATTERN_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .accept     (accept),
    .command    (command),
    .address    (address),
    .value      (value),
    .step       (step),
    .rd_addr    (rd_addr),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .carrier_on (carrier_on),
    .duration   (duration),
    .busy_res   (busy_res)
  );

endmodule

`default_nettype wire

[hdl/irpp_ctrl.sv]
`default_nettype none

// Playback sequencer: configuration registers, phase, part, position and
// flags. It updates once per accepted transaction and issues the pattern
// memory read address for that transaction.
module irpp_ctrl #(
  parameter int unsigned PATTERN_DEPTH = irpp_pkg::PATTERN_DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(PATTERN_DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step_en,
  input  wire logic [irpp_pkg::CMD_W-1:0]    command,
  input  wire logic                          cfg_we,
  input  wire logic [irpp_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [irpp_pkg::CFG_DW-1:0]   cfg_data,
  output irpp_pkg::step_t                    step,
  output logic [AW-1:0]                      rd_addr
);

  localparam int unsigned SW = (AW > 9) ? AW : 9;

  logic [7:0] offset_first, offset_repeat, offset_final;
  logic [7:0] length_first, length_repeat, length_final;

  irpp_pkg::phase_t phase, phase_next;
  logic [1:0]       active_part, active_part_next;
  logic [7:0]       position, position_next;
  logic             repeat_flag, repeat_flag_next;
  logic             stop_pending, stop_pending_next;

  logic [7:0]    cur_offset;
  logic [7:0]    cur_length;
  logic [8:0]    pos_inc;
  logic [SW-1:0] addr_sum;
  logic          final_differs;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_first  <= '0;
      offset_repeat <= '0;
      offset_final  <= '0;
      length_first  <= '0;
      length_repeat <= '0;
      length_final  <= '0;
    end else if (cfg_we) begin
      case (irpp_pkg::cfg_idx_t'(cfg_index))
        irpp_pkg::CFG_OFFSET_FIRST:  offset_first  <= cfg_data;
        irpp_pkg::CFG_OFFSET_REPEAT: offset_repeat <= cfg_data;
        irpp_pkg::CFG_OFFSET_FINAL:  offset_final  <= cfg_data;
        irpp_pkg::CFG_LENGTH_FIRST:  length_first  <= cfg_data;
        irpp_pkg::CFG_LENGTH_REPEAT: length_repeat <= cfg_data;
        irpp_pkg::CFG_LENGTH_FINAL:  length_final  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Offset and length of the part being played.
  always_comb begin
    case (active_part)
      irpp_pkg::PART_FIRST: begin
        cur_offset = offset_first;
        cur_length = length_first;
      end
      irpp_pkg::PART_REPEAT: begin
        cur_offset = offset_repeat;
        cur_length = length_repeat;
      end
      default: begin
        cur_offset = offset_final;
        cur_length = length_final;
      end
    endcase
  end

  assign pos_inc       = {1'b0, position} + 9'd1;
  assign final_differs = (offset_repeat != offset_final);

  // Next-state logic of the sequencer.
  always_comb begin
    phase_next        = phase;
    active_part_next  = active_part;
    position_next     = position;
    repeat_flag_next  = repeat_flag;
    stop_pending_next = stop_pending;
    case (irpp_pkg::cmd_t'(command))
      irpp_pkg::CMD_TICK: begin
        case (phase)
          irpp_pkg::PH_MARK: begin
            phase_next = irpp_pkg::PH_SPACE;
          end
          irpp_pkg::PH_SPACE: begin
            if (pos_inc >= {1'b0, cur_length}) begin
              position_next = '0;
              if (repeat_flag) begin
                phase_next       = irpp_pkg::PH_MARK;
                active_part_next = irpp_pkg::PART_REPEAT;
              end else if (stop_pending) begin
                // The stop part follows at once when its offset is distinct.
                stop_pending_next = 1'b0;
                active_part_next  = irpp_pkg::PART_FINAL;
                phase_next = final_differs ? irpp_pkg::PH_MARK : irpp_pkg::PH_IDLE;
              end else begin
                phase_next = irpp_pkg::PH_IDLE;
              end
            end else begin
              position_next = pos_inc[7:0];
              phase_next    = irpp_pkg::PH_MARK;
            end
          end
          default: begin
            phase_next = irpp_pkg::PH_IDLE;
          end
        endcase
      end
      irpp_pkg::CMD_START: begin
        active_part_next  = irpp_pkg::PART_FIRST;
        repeat_flag_next  = 1'b1;
        stop_pending_next = 1'b0;
        if (phase != irpp_pkg::PH_MARK && phase != irpp_pkg::PH_SPACE) begin
          position_next = '0;
          phase_next    = irpp_pkg::PH_MARK;
        end
      end
      irpp_pkg::CMD_STOP: begin
        repeat_flag_next = 1'b0;
        if (phase != irpp_pkg::PH_MARK && phase != irpp_pkg::PH_SPACE) begin
          active_part_next = irpp_pkg::PART_FINAL;
          position_next    = '0;
          phase_next = final_differs ? irpp_pkg::PH_MARK : irpp_pkg::PH_IDLE;
        end else if (active_part != irpp_pkg::PART_FINAL) begin
          stop_pending_next = 1'b1;
        end
      end
      default: begin
        // Table writes and unused codes leave playback alone.
        if (phase != irpp_pkg::PH_MARK && phase != irpp_pkg::PH_SPACE) begin
          phase_next = irpp_pkg::PH_IDLE;
        end
      end
    endcase
  end

  // Per-item outputs toward the datapath.
  always_comb begin
    step.has_dur = (irpp_pkg::cmd_t'(command) == irpp_pkg::CMD_TICK) &&
                   (phase == irpp_pkg::PH_MARK || phase == irpp_pkg::PH_SPACE);
    step.carrier = (irpp_pkg::cmd_t'(command) == irpp_pkg::CMD_TICK) &&
                   (phase == irpp_pkg::PH_MARK);
    step.busy    = (phase_next != irpp_pkg::PH_IDLE);
    addr_sum     = SW'(cur_offset) + SW'(position);
    rd_addr      = addr_sum[AW-1:0];
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= irpp_pkg::PH_IDLE;
      active_part  <= irpp_pkg::PART_FIRST;
      position     <= '0;
      repeat_flag  <= 1'b0;
      stop_pending <= 1'b0;
    end else if (step_en) begin
      phase        <= phase_next;
      active_part  <= active_part_next;
      position     <= position_next;
      repeat_flag  <= repeat_flag_next;
      stop_pending <= stop_pending_next;
    end
  end

endmodule

`default_nettype wire

[hdl/irpp_datapath.sv]
`default_nettype none

// Two-stage lookup datapath. Stage one reads the pattern memory, stage two
// reads the pulse-length table into the output register. Each stage holds
// its item until the next one is free.
module irpp_datapath #(
  parameter int unsigned PATTERN_DEPTH = irpp_pkg::PATTERN_DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(PATTERN_DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  output logic                               accept,
  input  wire logic [irpp_pkg::CMD_W-1:0]    command,
  input  wire logic [irpp_pkg::ADDR_W-1:0]   address,
  input  wire logic [irpp_pkg::VALUE_W-1:0]  value,
  input  wire irpp_pkg::step_t               step,
  input  wire logic [AW-1:0]                 rd_addr,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               carrier_on,
  output logic [irpp_pkg::DUR_W-1:0]         duration,
  output logic                               busy_res
);

  localparam int unsigned SW = (AW > 9) ? AW : 9;

  logic [irpp_pkg::BYTE_W-1:0] pattern_mem [PATTERN_DEPTH];
  logic [irpp_pkg::DUR_W-1:0]  pulse_mem   [irpp_pkg::PULSE_ENTRIES];

  logic                        s1_valid;
  irpp_pkg::step_t             s1_info;
  logic [irpp_pkg::BYTE_W-1:0] s1_byte;
  irpp_pkg::step_t             s2_info;
  logic [irpp_pkg::DUR_W-1:0]  s2_dur;

  logic                        s2_free;
  logic                        s1_adv;
  logic [SW-1:0]               wr_ext;
  logic [AW-1:0]               wr_addr;
  logic [irpp_pkg::PULSE_AW-1:0] pulse_idx;

  // Handshake: each stage moves when the one after it is free.
  assign s2_free  = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && s2_free;
  assign in_stall = s1_valid && !s2_free;
  assign accept   = in_valid && !in_stall;

  assign wr_ext  = SW'(address);
  assign wr_addr = wr_ext[AW-1:0];

  // Mark uses the high nibble of the pattern byte, space the low nibble.
  assign pulse_idx = s1_info.carrier ? s1_byte[7:4] : s1_byte[3:0];

  // Pattern memory: written and read at transaction acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (irpp_pkg::cmd_t'(command) == irpp_pkg::CMD_WRITE_PATTERN) begin
        pattern_mem[wr_addr] <= value[irpp_pkg::BYTE_W-1:0];
      end
      s1_byte <= pattern_mem[rd_addr];
      s1_info <= step;
    end
  end

  // Pulse table: written at acceptance, read as stage one moves on.
  always_ff @(posedge clk) begin
    if (accept && irpp_pkg::cmd_t'(command) == irpp_pkg::CMD_WRITE_PULSE) begin
      pulse_mem[address[irpp_pkg::PULSE_AW-1:0]] <= value;
    end
    if (s1_adv) begin
      s2_dur  <= pulse_mem[pulse_idx];
      s2_info <= s1_info;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result fields.
  assign carrier_on = s2_info.carrier;
  assign busy_res   = s2_info.busy;
  assign duration   = s2_info.has_dur ? s2_dur : '0;

endmodule

`default_nettype wire

[hdl/irpp_checker.sv]
`default_nettype none

// Port-level checks for the pattern player.
module irpp_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic                         carrier_on,
  input wire logic [irpp_pkg::DUR_W-1:0]   duration,
  input wire logic                         busy_res
);

  // A result held under stall stays valid.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A result held under stall keeps its fields.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(carrier_on) && $stable(duration) && $stable(busy_res))
    else $error("stalled result changed");

  // The input side only stalls while a finished result waits downstream.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // A mark is always followed by its space, so playback is still busy.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && carrier_on |-> busy_res)
    else $error("mark reported while not busy");

endmodule

bind ir_pulse_pattern_player irpp_checker u_irpp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .carrier_on (carrier_on),
  .duration   (duration),
  .busy_res   (busy_res)
);

`default_nettype wire

[test/ir_pulse_pattern_player_tb.sv]
`default_nettype none

module ir_pulse_pattern_player_tb;
  import irpp_pkg::*;

  localparam int CLK_HALF = 2;
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 4;
  localparam int END_CYCLES = 10;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 145;
  localparam int RUN_LIMIT = 4000000;
  localparam logic [CMD_W-1:0] CMD_CODE_LAST = '1;

  // One emitted interval as the block reports it.
  typedef struct {
    logic                carrier;
    logic [DUR_W-1:0]    dur;
    logic                busy;
  } emission_t;

  // Tracks the playback state and holds the intervals that are still owed.
  class ir_emission_scoreboard;
    phase_t            phase;
    logic [1:0]        part;
    logic [7:0]        pos;
    bit                repeat_on;
    bit                stop_armed;
    logic [DUR_W-1:0]  pulse_len [PULSE_ENTRIES];
    logic [BYTE_W-1:0] pattern [256];
    logic [7:0]        part_offset [3];
    logic [7:0]        part_pairs [3];
    emission_t         pending_emissions [$];
    int                mismatch_count;

    function new();
      phase = PH_IDLE;
      part = PART_FIRST;
      pos = '0;
      repeat_on = 1'b0;
      stop_armed = 1'b0;
      mismatch_count = 0;
      foreach (pulse_len[i]) pulse_len[i] = '0;
      foreach (pattern[i]) pattern[i] = '0;
      foreach (part_offset[i]) begin
        part_offset[i] = '0;
        part_pairs[i] = '0;
      end
    endfunction

    function void set_register(cfg_idx_t idx, logic [CFG_DW-1:0] data);
      case (idx)
        CFG_OFFSET_FIRST:  part_offset[PART_FIRST] = data;
        CFG_OFFSET_REPEAT: part_offset[PART_REPEAT] = data;
        CFG_OFFSET_FINAL:  part_offset[PART_FINAL] = data;
        CFG_LENGTH_FIRST:  part_pairs[PART_FIRST] = data;
        CFG_LENGTH_REPEAT: part_pairs[PART_REPEAT] = data;
        CFG_LENGTH_FINAL:  part_pairs[PART_FINAL] = data;
        default: ;
      endcase
    endfunction

    function logic [BYTE_W-1:0] current_byte();
      logic [7:0] a;
      a = part_offset[part] + pos;
      return pattern[a];
    endfunction

    // The stop part only plays when it lives apart from the repeat part.
    function void launch_stop_part();
      part = PART_FINAL;
      pos = '0;
      if (part_offset[PART_REPEAT] != part_offset[PART_FINAL]) phase = PH_MARK;
    endfunction

    function int pending();
      return pending_emissions.size();
    endfunction

    // Advance the playback state for one accepted transaction.
    function void note_command(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                               logic [VALUE_W-1:0] val);
      emission_t   r;
      logic [7:0]  b;
      logic [8:0]  next;
      r.carrier = 1'b0;
      r.dur = '0;
      case (cmd)
        CMD_TICK: begin
          if (phase == PH_MARK) begin
            b = current_byte();
            r.carrier = 1'b1;
            r.dur = pulse_len[b[7:4]];
            phase = PH_SPACE;
          end else if (phase == PH_SPACE) begin
            b = current_byte();
            r.dur = pulse_len[b[3:0]];
            next = {1'b0, pos} + 9'd1;
            if (next >= {1'b0, part_pairs[part]}) begin
              pos = '0;
              if (repeat_on) begin
                phase = PH_MARK;
                part = PART_REPEAT;
              end else begin
                phase = PH_IDLE;
                if (stop_armed) begin
                  stop_armed = 1'b0;
                  launch_stop_part();
                end
              end
            end else begin
              pos = next[7:0];
              phase = PH_MARK;
            end
          end
        end
        CMD_START: begin
          part = PART_FIRST;
          repeat_on = 1'b1;
          stop_armed = 1'b0;
          if (phase == PH_IDLE) begin
            pos = '0;
            phase = PH_MARK;
          end
        end
        CMD_STOP: begin
          repeat_on = 1'b0;
          if (phase == PH_IDLE) launch_stop_part();
          else if (part != PART_FINAL) stop_armed = 1'b1;
        end
        CMD_WRITE_PULSE: pulse_len[addr[PULSE_AW-1:0]] = val;
        CMD_WRITE_PATTERN: pattern[addr] = val[BYTE_W-1:0];
        default: ;
      endcase
      r.busy = (phase != PH_IDLE);
      pending_emissions.push_back(r);
    endfunction

    // Compare one delivered interval against the oldest one owed.
    function void check_emission(logic carrier, logic [DUR_W-1:0] dur, logic busy);
      emission_t e;
      if (pending_emissions.size() == 0) begin
        $display("%0t: unexpected result carrier_on=%0d duration=%0d busy_res=%0d",
                 $time, carrier, dur, busy);
        mismatch_count++;
        return;
      end
      e = pending_emissions.pop_front();
      if (carrier !== e.carrier) begin
        $display("%0t: carrier_on expected %0d actual %0d", $time, e.carrier, carrier);
        mismatch_count++;
      end
      if (dur !== e.dur) begin
        $display("%0t: duration expected %0d actual %0d", $time, e.dur, dur);
        mismatch_count++;
      end
      if (busy !== e.busy) begin
        $display("%0t: busy_res expected %0d actual %0d", $time, e.busy, busy);
        mismatch_count++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    command = CMD_TICK;
  logic [ADDR_W-1:0]   address = '0;
  logic [VALUE_W-1:0]  value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                carrier_on;
  logic [DUR_W-1:0]    duration;
  logic                busy_res;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index = CFG_OFFSET_FIRST;
  logic [CFG_DW-1:0]   cfg_data = '0;

  bit no_idle = 1'b0;
  bit hold_off_req = 1'b0;

  ir_emission_scoreboard emissions = new();

  ir_pulse_pattern_player DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .address    (address),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .carrier_on (carrier_on),
    .duration   (duration),
    .busy_res   (busy_res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Mostly short gaps, now and then a long one; none while running flat out.
  function automatic int pick_gap();
    int w;
    if (no_idle) return 0;
    w = $urandom_range(0, 99);
    if (w < 55) return 0;
    if (w < 90) return $urandom_range(1, 3);
    if (w < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'($urandom);
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    return VALUE_W'($urandom);
  endfunction

  function automatic logic [CFG_DW-1:0] pick_length();
    int w;
    w = $urandom_range(0, 99);
    if (w < 70) return CFG_DW'($urandom_range(0, 5));
    if (w < 92) return CFG_DW'($urandom_range(6, 20));
    return CFG_DW'($urandom_range(200, 255));
  endfunction

  // Offer one transaction and hold it until the block takes it.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                           input logic [VALUE_W-1:0] val);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    command = cmd;
    address = addr;
    value = val;
    do @(posedge clk); while (in_stall);
    emissions.note_command(cmd, addr, val);
  endtask

  // Stop offering and wait until every owed interval has come back.
  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (emissions.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    emissions.set_register(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input logic [7:0] off_first, input logic [7:0] off_rep,
                           input logic [7:0] off_fin, input logic [7:0] len_first,
                           input logic [7:0] len_rep, input logic [7:0] len_fin);
    wait_drain();
    write_reg(CFG_OFFSET_FIRST, off_first);
    write_reg(CFG_OFFSET_REPEAT, off_rep);
    write_reg(CFG_OFFSET_FINAL, off_fin);
    write_reg(CFG_LENGTH_FIRST, len_first);
    write_reg(CFG_LENGTH_REPEAT, len_rep);
    write_reg(CFG_LENGTH_FINAL, len_fin);
  endtask

  // Ticks dominate so that parts play through; the rest is control and table traffic.
  task automatic random_item();
    int w;
    w = $urandom_range(0, 99);
    if (w < 71) send_item(CMD_TICK, rand_addr(), rand_value());
    else if (w < 76) send_item(CMD_START, rand_addr(), rand_value());
    else if (w < 81) send_item(CMD_STOP, rand_addr(), rand_value());
    else if (w < 89) send_item(CMD_WRITE_PULSE, rand_addr(), rand_value());
    else if (w < 97) send_item(CMD_WRITE_PATTERN, rand_addr(), rand_value());
    else send_item(CMD_W'($urandom_range(int'(CMD_WRITE_PATTERN) + 1, int'(CMD_CODE_LAST))),
                   rand_addr(), rand_value());
  endtask

  // Check every transaction that leaves the block.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      emissions.check_emission(carrier_on, duration, busy_res);
    end
  end

  // Output back-pressure, including one long hold-off on request.
  initial begin : receiver
    int n;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        out_stall = 1'b0;
      end else begin
        n = pick_gap();
        out_stall = (n != 0);
        if (n > 1) repeat (n - 1) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int k;
    int phase_idx;
    logic [7:0] off_rep;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // A tick before anything is loaded finds the player idle.
    send_item(CMD_TICK, rand_addr(), rand_value());

    // Fill both tables so that no playback ever reads an empty entry.
    for (k = 0; k < PULSE_ENTRIES; k++) begin
      send_item(CMD_WRITE_PULSE, {4'($urandom), k[3:0]},
                (k == 0) ? 16'h0000 : (k == PULSE_ENTRIES - 1) ? 16'hffff : rand_value());
    end
    for (k = 0; k < 256; k++) begin
      send_item(CMD_WRITE_PATTERN, k[7:0], rand_value());
    end

    // Directed part: start part wraps around the end of pattern memory.
    configure(8'd254, 8'd16, 8'd40, 8'd3, 8'd2, 8'd1);
    send_item(CMD_STOP, rand_addr(), rand_value());
    send_item(CMD_STOP, rand_addr(), rand_value());
    send_item(CMD_TICK, rand_addr(), rand_value());
    send_item(CMD_TICK, rand_addr(), rand_value());
    send_item(CMD_START, rand_addr(), rand_value());
    repeat (3) send_item(CMD_TICK, rand_addr(), rand_value());
    // Restart while busy keeps the position.
    send_item(CMD_START, rand_addr(), rand_value());
    send_item(CMD_TICK, rand_addr(), rand_value());
    // A stop that is then overridden by a start.
    send_item(CMD_STOP, rand_addr(), rand_value());
    send_item(CMD_START, rand_addr(), rand_value());
    send_item(CMD_STOP, rand_addr(), rand_value());
    repeat (8) send_item(CMD_TICK, rand_addr(), rand_value());
    for (k = int'(CMD_WRITE_PATTERN) + 1; k <= int'(CMD_CODE_LAST); k++) begin
      send_item(CMD_W'(k), rand_addr(), rand_value());
    end
    send_item(CMD_WRITE_PULSE, 8'hff, 16'hffff);
    send_item(CMD_WRITE_PATTERN, 8'hff, 16'hffff);

    // Random phases, the first two at the register extremes.
    for (phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
      if (phase_idx == 0) begin
        configure(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      end else if (phase_idx == 1) begin
        configure(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
      end else begin
        off_rep = 8'($urandom);
        configure(8'($urandom), off_rep,
                  ($urandom_range(0, 3) == 0) ? off_rep : 8'($urandom),
                  pick_length(), pick_length(), pick_length());
      end
      no_idle = (phase_idx == 3 || phase_idx == 6);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (phase_idx == 6 && k == 20) hold_off_req = 1'b1;
        if (phase_idx == 4 && k == ITEMS_PER_PHASE / 2) wait_drain();
        random_item();
      end
      no_idle = 1'b0;
    end

    wait_drain();
    repeat (END_CYCLES) @(posedge clk);
    if (emissions.mismatch_count == 0 && emissions.pending() == 0) begin
      $display("ir_pulse_pattern_player regression: pass");
    end else begin
      $display("%0d results still owed, %0d mismatches",
               emissions.pending(), emissions.mismatch_count);
      $display("ir_pulse_pattern_player regression: fail");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #RUN_LIMIT;
    $display("ir_pulse_pattern_player regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
